FILE: rtl/core/json_string_escaper_utf8_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef JSON_STRING_ESCAPER_UTF8_TOP_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define JSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jse assertion failed");

// Next-cycle implication, switched off while reset is held.
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jse assertion failed");

// Next-cycle implication that stays active through reset.
`define JSE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("jse assertion failed");

`endif

FILE: rtl/core/jse_pkg.sv
package jse_pkg;

    localparam logic [6:0] C_BSLASH   = 7'h5C;
    localparam logic [6:0] C_LETTER_U = 7'h75;
    localparam logic [6:0] C_QUOTE    = 7'h22;
    localparam logic [6:0] C_SLASH    = 7'h2F;
    localparam logic [6:0] C_NUL      = 7'h00;

    localparam logic [3:0] C_CNT_ONE  = 4'd1;
    localparam logic [3:0] C_CNT_ESC  = 4'd2;
    localparam logic [3:0] C_CNT_UNIT = 4'd6;
    localparam logic [3:0] C_CNT_PAIR = 4'd12;

    typedef enum logic [1:0] {
        K_CHAR,
        K_ESC,
        K_UNIT
    } t_kind;

    // Everything one input item produces, expanded later one character a cycle while the output is not stalled.
    typedef struct packed {
        logic        has;
        t_kind       kind;
        logic [3:0]  cnt;
        logic [6:0]  chr;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_res;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] r;
        if (nib < 4'd10) begin
            r = 7'h30 + {3'b000, nib};
        end else begin
            r = 7'h37 + {3'b000, nib};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/jse_decode.sv
module jse_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output jse_pkg::t_res    o_res
);

    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_left, n_left;
    logic [7:0]  r_lead, n_lead;
    logic        r_first, n_first;
    logic        r_err, n_err;

    logic [20:0] cp;
    logic [19:0] sp;
    logic        bad;
    jse_pkg::t_res res;

    assign cp = {r_acc[14:0], i_byte[5:0]};
    assign sp = cp[19:0] - 20'h10000;

    always_comb begin
        n_acc   = r_acc;
        n_left  = r_left;
        n_lead  = r_lead;
        n_first = r_first;
        n_err   = r_err;
        bad     = 1'b0;
        res.has  = 1'b0;
        res.kind = jse_pkg::K_CHAR;
        res.cnt  = jse_pkg::C_CNT_ONE;
        res.chr  = i_byte[6:0];
        res.u0   = {8'h00, i_byte};
        res.u1   = {6'b110111, sp[9:0]};
        if (i_byte == 8'h00) begin
            // End of string: success only with no error and no open sequence.
            if (!r_err && r_left == 2'd0) begin
                res.has = 1'b1;
                res.chr = jse_pkg::C_NUL;
            end
            n_acc   = '0;
            n_left  = '0;
            n_lead  = '0;
            n_first = 1'b0;
            n_err   = 1'b0;
        end else if (r_err) begin
            n_err = 1'b1;
        end else if (r_left != 2'd0) begin
            bad = (i_byte[7:6] != 2'b10) ||
                  (r_first && ((r_lead == 8'hE0 && i_byte < 8'hA0) ||
                               (r_lead == 8'hF0 && i_byte < 8'h90) ||
                               (r_lead == 8'hF4 && i_byte >= 8'h90)));
            if (bad) begin
                n_err   = 1'b1;
                n_acc   = '0;
                n_left  = '0;
                n_lead  = '0;
                n_first = 1'b0;
            end else begin
                n_first = 1'b0;
                n_acc   = cp;
                n_left  = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    n_acc  = '0;
                    n_lead = '0;
                    if ((cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF) begin
                        n_err = 1'b1;
                    end else if (cp <= 21'h00FFFF) begin
                        res.has  = 1'b1;
                        res.kind = jse_pkg::K_UNIT;
                        res.cnt  = jse_pkg::C_CNT_UNIT;
                        res.u0   = cp[15:0];
                    end else begin
                        res.has  = 1'b1;
                        res.kind = jse_pkg::K_UNIT;
                        res.cnt  = jse_pkg::C_CNT_PAIR;
                        res.u0   = {6'b110110, sp[19:10]};
                    end
                end
            end
        end else if (i_byte < 8'h20) begin
            res.has  = 1'b1;
            res.kind = jse_pkg::K_UNIT;
            res.cnt  = jse_pkg::C_CNT_UNIT;
        end else if (i_byte < 8'h80) begin
            res.has = 1'b1;
            if (i_byte[6:0] == jse_pkg::C_QUOTE || i_byte[6:0] == jse_pkg::C_BSLASH ||
                i_byte[6:0] == jse_pkg::C_SLASH) begin
                res.kind = jse_pkg::K_ESC;
                res.cnt  = jse_pkg::C_CNT_ESC;
            end
        end else if (i_byte < 8'hC2 || i_byte >= 8'hF5) begin
            n_err = 1'b1;
        end else begin
            n_lead  = i_byte;
            n_first = 1'b1;
            if (i_byte < 8'hE0) begin
                n_acc  = {16'h0000, i_byte[4:0]};
                n_left = 2'd1;
            end else if (i_byte < 8'hF0) begin
                n_acc  = {17'h00000, i_byte[3:0]};
                n_left = 2'd2;
            end else begin
                n_acc  = {18'h00000, i_byte[2:0]};
                n_left = 2'd3;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_left  <= '0;
            r_lead  <= '0;
            r_first <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_lead  <= n_lead;
            r_first <= n_first;
            r_err   <= n_err;
        end
    end

endmodule

FILE: rtl/core/jse_emit.sv
module jse_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jse_pkg::t_res    i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [6:0]       o_char
);

    logic          r_valid;
    jse_pkg::t_res r_res;
    logic [3:0]    r_idx;

    logic          take;
    logic          last;
    logic          hi;
    logic [2:0]    pos;
    logic [3:0]    pos_w;
    logic [15:0]   unit;

    assign take    = r_valid && !i_stall;
    assign last    = (r_idx == (r_res.cnt - 4'd1));
    assign o_ready = !r_valid || (take && last);
    assign o_valid = r_valid;

    // The second code unit of a surrogate pair starts at character six.
    assign hi    = (r_idx >= 4'd6);
    assign pos_w = hi ? (r_idx - 4'd6) : r_idx;
    assign pos   = pos_w[2:0];
    assign unit  = hi ? r_res.u1 : r_res.u0;

    always_comb begin
        o_char = jse_pkg::C_NUL;
        unique case (r_res.kind)
            jse_pkg::K_CHAR: begin
                o_char = r_res.chr;
            end
            jse_pkg::K_ESC: begin
                o_char = (r_idx == 4'd0) ? jse_pkg::C_BSLASH : r_res.chr;
            end
            jse_pkg::K_UNIT: begin
                unique case (pos)
                    3'd0:    o_char = jse_pkg::C_BSLASH;
                    3'd1:    o_char = jse_pkg::C_LETTER_U;
                    3'd2:    o_char = jse_pkg::hex_char(unit[15:12]);
                    3'd3:    o_char = jse_pkg::hex_char(unit[11:8]);
                    3'd4:    o_char = jse_pkg::hex_char(unit[7:4]);
                    3'd5:    o_char = jse_pkg::hex_char(unit[3:0]);
                    default: o_char = jse_pkg::C_NUL;
                endcase
            end
            default: o_char = jse_pkg::C_NUL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/core/json_string_escaper_utf8_top.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_in_byte  (8 bits)
// output    out        o_valid / i_stall  o_out_char (7 bits)
//
// An input item is registered, decoded in one pass and written to the result
// register once the emitter is ready; it then leaves at one character per cycle while the output is not stalled.
// Items expand to 0, 1, 2, 6 or 12 characters; a control byte expands to six.
// Reset is synchronous and active low and clears the UTF-8 state and both stages.
// A stall on the output holds the result register and, once it is full, the
// input register too.
module json_string_escaper_utf8_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;

    logic          emit_ready;
    logic          advance;
    logic          accept;
    jse_pkg::t_res res;

    assign advance = r_in_valid && emit_ready;
    assign o_stall = r_in_valid && !emit_ready;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    jse_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    jse_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res.has),
        .i_res   (res),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_char  (o_out_char)
    );

endmodule

FILE: rtl/core/jse_checker.sv
`include "json_string_escaper_utf8_top_assert.svh"

module jse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_in_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_out_char
);

    // With the result register empty the input side is never held.
    `JSE_ASSERT_NOW(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall)

    // A held input item stays offered and unchanged.
    `JSE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_in_byte))

    // A held character stays valid and unchanged.
    `JSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_char))

    // Reset empties both stages.
    `JSE_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind json_string_escaper_utf8_top jse_checker u_jse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_in_byte  (i_in_byte),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_char (o_out_char)
);

FILE: sim/tb_top.sv
module tb_top;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_TAIL  = 16;
    localparam int PHASE_ITEMS = 72;

    localparam logic [7:0] END_OF_STRING = 8'h00;
    localparam logic [7:0] FIRST_PRINT   = 8'h20;
    localparam logic [7:0] FIRST_MULTI   = 8'h80;
    localparam logic [7:0] MIN_LEAD      = 8'hC2;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] PAST_LEAD     = 8'hF5;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_char;

    json_string_escaper_utf8_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Decoder state of the escaper as the testbench tracks it.
    logic [20:0] utf_accum;
    logic [1:0]  utf_left;
    logic [7:0]  utf_lead;
    logic        utf_first;
    logic        utf_error;

    logic [6:0] expected_chars[$];
    logic [6:0] want_char;
    int         errors        = 0;
    int         bytes_sent    = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         quiet_cycles  = 0;

    initial begin
        utf_accum = '0;
        utf_left  = '0;
        utf_lead  = '0;
        utf_first = 1'b0;
        utf_error = 1'b0;
    end

    function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'h30 + {3'b000, nib};
        end
        return 7'h41 + {3'b000, nib} - 7'd10;
    endfunction

    task automatic queue_char(input logic [6:0] c);
        expected_chars.insert(expected_chars.size(), c);
    endtask

    task automatic clear_sequence();
        utf_accum = '0;
        utf_left  = '0;
        utf_lead  = '0;
        utf_first = 1'b0;
    endtask

    task automatic push_unit(input logic [15:0] unit);
        queue_char(jse_pkg::C_BSLASH);
        queue_char(jse_pkg::C_LETTER_U);
        queue_char(nibble_ascii(unit[15:12]));
        queue_char(nibble_ascii(unit[11:8]));
        queue_char(nibble_ascii(unit[7:4]));
        queue_char(nibble_ascii(unit[3:0]));
    endtask

    task automatic push_code_point(input logic [20:0] cp);
        logic [20:0] offs;
        if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
            utf_error = 1'b1;
        end else if (cp <= 21'h00FFFF) begin
            push_unit(cp[15:0]);
        end else if (cp > 21'h10FFFF) begin
            utf_error = 1'b1;
        end else begin
            offs = cp - 21'h010000;
            push_unit({6'b000000, offs[19:10]} + 16'hD800);
            push_unit({6'b000000, offs[9:0]} + 16'hDC00);
        end
    endtask

    // Works out the characters that one accepted input item produces.
    task automatic escape_byte(input logic [7:0] b);
        logic [20:0] cp;
        if (b == END_OF_STRING) begin
            // A missing end character is how the block reports a bad string.
            if (!utf_error && utf_left == 2'd0) begin
                queue_char(jse_pkg::C_NUL);
            end
            clear_sequence();
            utf_error = 1'b0;
        end else if (utf_error) begin
        end else if (utf_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                utf_error = 1'b1;
                clear_sequence();
            end else if (utf_first && ((utf_lead == LEAD_E0 && b < 8'hA0) ||
                                       (utf_lead == LEAD_F0 && b < 8'h90) ||
                                       (utf_lead == LEAD_F4 && b >= 8'h90))) begin
                utf_error = 1'b1;
                clear_sequence();
            end else begin
                utf_first = 1'b0;
                utf_accum = {utf_accum[14:0], b[5:0]};
                utf_left  = utf_left - 2'd1;
                if (utf_left == 2'd0) begin
                    cp = utf_accum;
                    clear_sequence();
                    push_code_point(cp);
                end
            end
        end else if (b < FIRST_PRINT) begin
            push_unit({8'h00, b});
        end else if (b < FIRST_MULTI) begin
            if (b[6:0] == jse_pkg::C_QUOTE || b[6:0] == jse_pkg::C_BSLASH ||
                b[6:0] == jse_pkg::C_SLASH) begin
                queue_char(jse_pkg::C_BSLASH);
            end
            queue_char(b[6:0]);
        end else if (b < MIN_LEAD || b >= PAST_LEAD) begin
            utf_error = 1'b1;
        end else begin
            utf_lead  = b;
            utf_first = 1'b1;
            if (b < LEAD_E0) begin
                utf_accum = {16'd0, b[4:0]};
                utf_left  = 2'd1;
            end else if (b < LEAD_F0) begin
                utf_accum = {17'd0, b[3:0]};
                utf_left  = 2'd2;
            end else begin
                utf_accum = {18'd0, b[2:0]};
                utf_left  = 2'd3;
            end
        end
    endtask

    // Both channels are sampled here, so prediction and checking see one cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            escape_byte(i_in_byte);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected out_char expected none, got %h", $time, o_out_char);
                errors++;
            end else begin
                want_char = expected_chars.pop_front();
                if (o_out_char !== want_char) begin
                    $display("%0t: out_char mismatch expected %h, got %h",
                             $time, want_char, o_out_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves valid high on return so that a following item can go back to back.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_code_point(input logic [20:0] cp);
        if (cp < 21'h000800) begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h010000) begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end else begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic send_valid_sequence();
        logic [20:0] cp;
        case ($urandom_range(2))
            0: cp = 21'($urandom_range(21'h000080, 21'h0007FF));
            1: begin
                do cp = 21'($urandom_range(21'h000800, 21'h00FFFF));
                while (cp >= 21'h00D800 && cp <= 21'h00DFFF);
            end
            default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
        endcase
        send_code_point(cp);
    endtask

    task automatic send_broken_sequence();
        logic [7:0] v;
        case ($urandom_range(7))
            0: send_byte(8'($urandom_range(8'h80, 8'hBF)));
            1: begin
                v = 8'($urandom_range(0, 12));
                send_byte(v < 8'd2 ? 8'hC0 + v : 8'hF3 + v);
            end
            2: begin
                send_byte(LEAD_E0);
                send_byte(8'($urandom_range(8'h80, 8'h9F)));
            end
            3: begin
                send_byte(LEAD_F0);
                send_byte(8'($urandom_range(8'h80, 8'h8F)));
            end
            4: begin
                send_byte(LEAD_F4);
                send_byte(8'($urandom_range(8'h90, 8'hBF)));
            end
            5: begin
                // Encodes a surrogate, which UTF-8 forbids.
                send_byte(LEAD_ED);
                send_byte(8'($urandom_range(8'hA0, 8'hBF)));
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            6: begin
                send_byte(8'($urandom_range(MIN_LEAD, LEAD_F4)));
                do v = 8'($urandom_range(1, 255)); while (v[7:6] == 2'b10);
                send_byte(v);
            end
            default: send_byte(8'($urandom_range(MIN_LEAD, LEAD_F4)));
        endcase
    endtask

    task automatic send_random_string();
        int nchars;
        int pick;
        nchars = $urandom_range(0, 7);
        repeat (nchars) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (pick < 85) begin
                send_valid_sequence();
            end else begin
                send_broken_sequence();
            end
        end
        send_byte(END_OF_STRING);
    endtask

    task automatic test_directed_cases();
        logic [7:0] seq [0:25] = '{
            8'h01, 8'h1F, 8'h22, 8'h5C, 8'h2F, 8'h7F, 8'h00,
            8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'h00,
            8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
            8'hED, 8'hA0, 8'h80, 8'hFF, 8'h00,
            8'hF4, 8'h90, 8'h00
        };
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (seq[k]) begin
            send_byte(seq[k]);
        end
    endtask

    task automatic test_random_strings(input int send_pct, input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        target        = bytes_sent + PHASE_ITEMS;
        while (bytes_sent < target) begin
            send_random_string();
        end
    endtask

    // A control byte expands to six characters; the sender then waits until they have drained.
    task automatic test_drain_pause();
        send_byte(8'h01);
        send_byte(END_OF_STRING);
        hold_until_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_strings(0, 0);
        test_random_strings(71, 0);
        test_drain_pause();
        test_random_strings(0, 71);
        test_random_strings(25, 25);
        test_drain_pause();
        hold_until_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: json_string_escaper_utf8_top.f
+incdir+rtl/core
rtl/core/jse_pkg.sv
rtl/core/jse_decode.sv
rtl/core/jse_emit.sv
rtl/core/json_string_escaper_utf8_top.sv
rtl/core/jse_checker.sv
sim/tb_top.sv
